### design/atp_pkg.sv
// atp_pkg: shared types, widths and the cordic arctangent table for the tilt core
// no dependencies
`timescale 1ns / 1ps

package atp_pkg;

	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int OUT_BITS   = 15;
	localparam int RAD_BITS   = 62;
	localparam int ROOT_BITS  = 63;
	localparam int ROOT_STEPS = 31;
	localparam int VEC_BITS   = 64;
	localparam int ZFRAC      = 20;
	localparam int ZW         = 32;
	localparam int TABLE_LEN  = 24;

	typedef struct packed {
		logic neg;
		logic num_zero;
		logic mag_zero;
	} lane_side_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 32'sd47185920;
			1:  v = 32'sd27855475;
			2:  v = 32'sd14718068;
			3:  v = 32'sd7471121;
			4:  v = 32'sd3750058;
			5:  v = 32'sd1876857;
			6:  v = 32'sd938658;
			7:  v = 32'sd469357;
			8:  v = 32'sd234682;
			9:  v = 32'sd117342;
			10: v = 32'sd58671;
			11: v = 32'sd29335;
			12: v = 32'sd14668;
			13: v = 32'sd7334;
			14: v = 32'sd3667;
			15: v = 32'sd1833;
			16: v = 32'sd917;
			17: v = 32'sd458;
			18: v = 32'sd229;
			19: v = 32'sd115;
			20: v = 32'sd57;
			21: v = 32'sd29;
			22: v = 32'sd14;
			23: v = 32'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### design/atp_sqrt_cell.sv
// atp_sqrt_cell: one digit step of the restoring integer square root
// depends on atp_pkg
`timescale 1ns / 1ps

module atp_sqrt_cell #(
	parameter int BIT_POS = 60
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [atp_pkg::ROOT_BITS-1:0]       rem_in,
	input  logic [atp_pkg::ROOT_BITS-1:0]       root_in,
	input  logic signed [atp_pkg::VEC_BITS-1:0] y_in,
	input  atp_pkg::lane_side_t                 side_in,
	output logic [atp_pkg::ROOT_BITS-1:0]       rem_q,
	output logic [atp_pkg::ROOT_BITS-1:0]       root_q,
	output logic signed [atp_pkg::VEC_BITS-1:0] y_q,
	output atp_pkg::lane_side_t                 side_q
);

	localparam logic [atp_pkg::ROOT_BITS-1:0] BITV = atp_pkg::ROOT_BITS'(1) << BIT_POS;

	logic [atp_pkg::ROOT_BITS-1:0] trial;

	assign trial = root_in + BITV;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= (root_in >> 1) + BITV;
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in >> 1;
			end
			y_q    <= y_in;
			side_q <= side_in;
		end
	end

endmodule

### design/atp_cordic_cell.sv
// atp_cordic_cell: one vectoring cordic rotation with its angle step
// depends on atp_pkg
`timescale 1ns / 1ps

module atp_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [atp_pkg::VEC_BITS-1:0] x_in,
	input  logic signed [atp_pkg::VEC_BITS-1:0] y_in,
	input  logic signed [atp_pkg::ZW-1:0]       z_in,
	input  atp_pkg::lane_side_t                 side_in,
	output logic signed [atp_pkg::VEC_BITS-1:0] x_q,
	output logic signed [atp_pkg::VEC_BITS-1:0] y_q,
	output logic signed [atp_pkg::ZW-1:0]       z_q,
	output atp_pkg::lane_side_t                 side_q
);

	localparam logic signed [atp_pkg::ZW-1:0] ANG = atp_pkg::atan_tab(STAGE);

	logic signed [atp_pkg::VEC_BITS-1:0] xs, ys;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[atp_pkg::VEC_BITS-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ANG;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ANG;
			end
			side_q <= side_in;
		end
	end

endmodule

### design/accel_tilt_pitch_roll_core.sv
// accel_tilt_pitch_roll_core: pitch and roll from one accelerometer sample
// depends on atp_pkg, atp_sqrt_cell, atp_cordic_cell
//
// channel | signals                               | direction
// in      | in_valid in_ready accel_x/y/z          | request in
// out     | out_valid out_ready pitch/roll_angle   | request out
//
// one request per cycle while the output register is empty or out_ready is high; a sample passes
// the input, square, sum and normalise registers, then the square root and cordic cell rows of each lane
// arst_n clears all valid bits; payload registers are not reset
// a stalled output holds the whole pipeline; bubbles pass with no cost
`timescale 1ns / 1ps

module accel_tilt_pitch_roll_core #(
	parameter int SAMPLE_BITS     = atp_pkg::SAMPLE_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = atp_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = atp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        accel_x,
	input  logic signed [SAMPLE_BITS-1:0]        accel_y,
	input  logic signed [SAMPLE_BITS-1:0]        accel_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [atp_pkg::OUT_BITS-1:0]  pitch_angle,
	output logic signed [atp_pkg::OUT_BITS-1:0]  roll_angle
);

	localparam int SQ_BITS = 2 * SAMPLE_BITS;
	localparam int NST     = 4 + atp_pkg::ROOT_STEPS + CORDIC_STAGES;
	localparam int SHR     = atp_pkg::ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [atp_pkg::ZW-1:0] ZMAX = atp_pkg::ZW'(90) <<< atp_pkg::ZFRAC;
	localparam logic signed [atp_pkg::ZW-1:0] HALF = atp_pkg::ZW'(1) <<< (SHR - 1);
	localparam logic signed [atp_pkg::OUT_BITS:0] FULL =
		(atp_pkg::OUT_BITS + 1)'(90) <<< ANGLE_FRAC_BITS;

	logic en;
	logic [NST-1:0] vld_q;
	logic out_valid_q;

	logic signed [SAMPLE_BITS-1:0] x_s1, y_s1, z_s1, x_s2, y_s2;
	logic signed [SQ_BITS-1:0] xx_s2, yy_s2, zz_s2;

	logic signed [SAMPLE_BITS-1:0] num_s2 [0:1];
	logic signed [SQ_BITS-1:0]     sqa_s2 [0:1];
	logic signed [SQ_BITS-1:0]     sqb_s2 [0:1];
	logic signed [atp_pkg::OUT_BITS-1:0] ang_q [0:1];

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign pitch_angle = ang_q[0];
	assign roll_angle  = ang_q[1];

	assign num_s2[0] = x_s2;
	assign sqa_s2[0] = yy_s2;
	assign sqb_s2[0] = zz_s2;
	assign num_s2[1] = y_s2;
	assign sqa_s2[1] = xx_s2;
	assign sqb_s2[1] = zz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[NST-2:0], in_valid};
			out_valid_q <= vld_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= accel_x;
			y_s1  <= accel_y;
			z_s1  <= accel_z;
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
		end
	end

	function automatic logic [atp_pkg::RAD_BITS+4:0] normalize(
		input logic [atp_pkg::RAD_BITS-1:0] s
	);
		logic [atp_pkg::RAD_BITS-1:0] v;
		logic [4:0] k;
		v = s;
		k = '0;
		if (v[61:30] == '0) begin
			v = v << 32;
			k = k + 5'd16;
		end
		if (v[61:46] == '0) begin
			v = v << 16;
			k = k + 5'd8;
		end
		if (v[61:54] == '0) begin
			v = v << 8;
			k = k + 5'd4;
		end
		if (v[61:58] == '0) begin
			v = v << 4;
			k = k + 5'd2;
		end
		if (v[61:60] == '0) begin
			v = v << 2;
			k = k + 5'd1;
		end
		return {k, v};
	endfunction

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [atp_pkg::RAD_BITS-1:0] s_s3;
		logic [SAMPLE_BITS-1:0] n_s3;
		atp_pkg::lane_side_t side_s3;
		logic [atp_pkg::RAD_BITS+4:0] nrm;
		logic [atp_pkg::VEC_BITS-1:0] n_ext;

		logic [atp_pkg::ROOT_BITS-1:0] rem [0:atp_pkg::ROOT_STEPS];
		logic [atp_pkg::ROOT_BITS-1:0] root [0:atp_pkg::ROOT_STEPS];
		logic signed [atp_pkg::VEC_BITS-1:0] sy [0:atp_pkg::ROOT_STEPS];
		atp_pkg::lane_side_t sside [0:atp_pkg::ROOT_STEPS];

		logic signed [atp_pkg::VEC_BITS-1:0] cx [0:CORDIC_STAGES];
		logic signed [atp_pkg::VEC_BITS-1:0] cy [0:CORDIC_STAGES];
		logic signed [atp_pkg::ZW-1:0] cz [0:CORDIC_STAGES];
		atp_pkg::lane_side_t cside [0:CORDIC_STAGES];

		logic signed [atp_pkg::ZW-1:0] zc, zr;
		logic signed [atp_pkg::OUT_BITS:0] mag, res;

		always_ff @(posedge clk) begin
			if (en) begin
				s_s3 <= atp_pkg::RAD_BITS'(unsigned'(sqa_s2[l])) +
					atp_pkg::RAD_BITS'(unsigned'(sqb_s2[l]));
				n_s3 <= num_s2[l][SAMPLE_BITS-1] ? SAMPLE_BITS'(-num_s2[l])
					: SAMPLE_BITS'(num_s2[l]);
				side_s3.neg      <= num_s2[l][SAMPLE_BITS-1];
				side_s3.num_zero <= (num_s2[l] == '0);
				side_s3.mag_zero <= (sqa_s2[l] == '0) && (sqb_s2[l] == '0);
			end
		end

		assign nrm   = normalize(s_s3);
		assign n_ext = atp_pkg::VEC_BITS'(n_s3);

		always_ff @(posedge clk) begin
			if (en) begin
				rem[0]   <= atp_pkg::ROOT_BITS'(nrm[atp_pkg::RAD_BITS-1:0]);
				root[0]  <= '0;
				sy[0]    <= signed'(n_ext << nrm[atp_pkg::RAD_BITS+4:atp_pkg::RAD_BITS]);
				sside[0] <= side_s3;
			end
		end

		for (genvar j = 0; j < atp_pkg::ROOT_STEPS; j++) begin : g_sqrt
			atp_sqrt_cell #(
				.BIT_POS(2 * (atp_pkg::ROOT_STEPS - 1 - j))
			) u_cell (
				.clk    (clk),
				.en     (en),
				.rem_in (rem[j]),
				.root_in(root[j]),
				.y_in   (sy[j]),
				.side_in(sside[j]),
				.rem_q  (rem[j+1]),
				.root_q (root[j+1]),
				.y_q    (sy[j+1]),
				.side_q (sside[j+1])
			);
		end

		assign cx[0]    = signed'(atp_pkg::VEC_BITS'(root[atp_pkg::ROOT_STEPS]));
		assign cy[0]    = sy[atp_pkg::ROOT_STEPS];
		assign cz[0]    = '0;
		assign cside[0] = sside[atp_pkg::ROOT_STEPS];

		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
			atp_cordic_cell #(
				.STAGE(i)
			) u_cell (
				.clk    (clk),
				.en     (en),
				.x_in   (cx[i]),
				.y_in   (cy[i]),
				.z_in   (cz[i]),
				.side_in(cside[i]),
				.x_q    (cx[i+1]),
				.y_q    (cy[i+1]),
				.z_q    (cz[i+1]),
				.side_q (cside[i+1])
			);
		end

		always_comb begin
			zc = cz[CORDIC_STAGES];
			if (zc < 0) begin
				zc = '0;
			end
			if (zc > ZMAX) begin
				zc = ZMAX;
			end
			zr  = (zc + HALF) >>> SHR;
			mag = (atp_pkg::OUT_BITS + 1)'(zr);
			if (cside[CORDIC_STAGES].num_zero) begin
				res = '0;
			end else if (cside[CORDIC_STAGES].mag_zero) begin
				res = cside[CORDIC_STAGES].neg ? -FULL : FULL;
			end else begin
				res = cside[CORDIC_STAGES].neg ? -mag : mag;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ang_q[l] <= atp_pkg::OUT_BITS'(res);
			end
		end
	end

endmodule

### design/atp_checker.sv
// atp_checker: port-level checks for the tilt core, bound to the top level
// depends on accel_tilt_pitch_roll_core
`timescale 1ns / 1ps

module atp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [14:0] pitch_angle,
	input logic [14:0] roll_angle
);

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(roll_angle))
		else $error("result dropped or changed while stalled");

	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output side");

	ap_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(pitch_angle) <= 15'sd11520) && ($signed(pitch_angle) >= -15'sd11520))
		else $error("pitch out of range");

	ap_roll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(roll_angle) <= 15'sd11520) && ($signed(roll_angle) >= -15'sd11520))
		else $error("roll out of range");

endmodule

bind accel_tilt_pitch_roll_core atp_checker u_atp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pitch_angle(pitch_angle),
	.roll_angle (roll_angle)
);

### test/accel_tilt_pitch_roll_core_tb.sv
// accel_tilt_pitch_roll_core_tb: random and directed regression of the tilt core
// predicts pitch and roll with a bit-exact integer cordic model in a scoreboard class
// depends on atp_pkg and accel_tilt_pitch_roll_core
`timescale 1ns / 1ps

class tilt_scoreboard;
	typedef struct {
		logic signed [atp_pkg::OUT_BITS-1:0] pitch;
		logic signed [atp_pkg::OUT_BITS-1:0] roll;
	} angle_pair_t;

	angle_pair_t pending[$];
	int mismatches = 0;
	int checked = 0;

	static function automatic longint atan_deg(int i);
		longint tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
			938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
			917, 458, 229, 115, 57, 29, 14, 7};
		return tab[i];
	endfunction

	static function automatic logic signed [atp_pkg::OUT_BITS-1:0] tilt_angle(
		longint num, longint a, longint b);
		longint unsigned s, t, v, rt, bt;
		longint n, cx, cy, cz, xs, ys, r;
		int bl, k;
		s = longint'(a * a) + longint'(b * b);
		if (num == 0)
			return '0;
		if (s == 0)
			return atp_pkg::OUT_BITS'((num < 0) ? -(90 <<< 7) : (90 <<< 7));
		n = (num < 0) ? -num : num;
		bl = 0;
		for (t = s; t != 0; t = t >> 1)
			bl++;
		k = (62 - bl) / 2;
		v = s << (2 * k);
		rt = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= rt + bt) begin
				v = v - (rt + bt);
				rt = (rt >> 1) + bt;
			end else begin
				rt = rt >> 1;
			end
			bt = bt >> 2;
		end
		cx = longint'(rt);
		cy = n <<< k;
		cz = 0;
		for (int i = 0; i < 16; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy >= 0) begin
				cx = cx + ys;
				cy = cy - xs;
				cz = cz + atan_deg(i);
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				cz = cz - atan_deg(i);
			end
		end
		if (cz < 0)
			cz = 0;
		if (cz > (longint'(90) <<< 20))
			cz = longint'(90) <<< 20;
		r = (cz + (longint'(1) <<< 12)) >>> 13;
		if (num < 0)
			r = -r;
		return r[atp_pkg::OUT_BITS-1:0];
	endfunction

	function void note(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
		angle_pair_t e;
		e.pitch = tilt_angle(x, y, z);
		e.roll = tilt_angle(y, x, z);
		pending.push_back(e);
	endfunction

	function void check(logic signed [atp_pkg::OUT_BITS-1:0] p,
		logic signed [atp_pkg::OUT_BITS-1:0] r);
		angle_pair_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result pitch=%0d roll=%0d", p, r);
			return;
		end
		e = pending.pop_front();
		if (p !== e.pitch || r !== e.roll) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch #%0d: pitch exp %0d got %0d, roll exp %0d got %0d",
					checked, e.pitch, p, e.roll, r);
		end
	endfunction
endclass

module accel_tilt_pitch_roll_core_tb;
	localparam int RANDOM_SAMPLES = 1700;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic out_valid;
	logic out_ready;
	logic signed [atp_pkg::OUT_BITS-1:0] pitch_angle, roll_angle;

	tilt_scoreboard sb = new();
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;

	always #2 clk = ~clk;

	accel_tilt_pitch_roll_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.pitch_angle(pitch_angle), .roll_angle(roll_angle)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do @(posedge clk); while (!in_ready);
		sb.note(x, y, z);
		sent++;
	endtask

	function automatic logic signed [15:0] rand_axis(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 510)) - 255);
			2: return 16'($signed($urandom_range(0, 4000)) - 2000);
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sh0000;
					3: return 16'sh0001;
					default: return 16'shffff;
				endcase
			end
		endcase
	endfunction

	// receiver with random back-pressure
	initial begin
		int w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 11);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check(pitch_angle, roll_angle);
		end
	end

	initial begin
		logic signed [15:0] x, y, z;
		int mode, g;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		accel_x <= '0;
		accel_y <= '0;
		accel_z <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero, zero numerators, zero magnitude, extremes
		send_sample(0, 0, 0);
		send_sample(0, 0, 16384);
		send_sample(0, 0, -32768);
		send_sample(100, 0, 0);
		send_sample(-100, 0, 0);
		send_sample(0, 1, 0);
		send_sample(0, -1, 0);
		send_sample(-32768, -32768, -32768);
		send_sample(32767, 32767, 32767);
		send_sample(-32768, 32767, 0);
		send_sample(32767, -32768, 0);
		send_sample(-32768, 0, 0);
		send_sample(0, -32768, 0);
		send_sample(1, 1, 1);
		send_sample(-1, -1, -1);
		send_sample(1, 0, -32768);
		send_sample(-32768, 1, 0);
		send_sample(16384, 16384, 0);
		send_sample(-11585, 11585, 16384);
		send_sample(32767, 0, 1);

		for (int i = 0; i < RANDOM_SAMPLES; i++) begin
			if (i % 200 == 0)
				calm = ($urandom_range(0, 2) == 0);
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				x = rand_axis(0); y = rand_axis(0); z = rand_axis(0);
			end else if (mode < 6) begin
				x = rand_axis(1); y = rand_axis(1); z = rand_axis(1);
			end else if (mode < 8) begin
				// near-static gravity along a random axis
				g = $urandom_range(0, 1) ? 16384 : -16384;
				x = rand_axis(2); y = rand_axis(2); z = rand_axis(2);
				case ($urandom_range(0, 2))
					0: x = x + 16'(g);
					1: y = y + 16'(g);
					default: z = z + 16'(g);
				endcase
			end else begin
				x = rand_axis(3 - $urandom_range(0, 1) * 3);
				y = rand_axis(3);
				z = rand_axis(3 - $urandom_range(0, 1) * 2);
			end
			send_sample(x, y, z);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d samples sent (directed corners, zero and full-scale axes, random mixes)",
			sent);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
